// ===== hdl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants for lidar gap steering
// Register indexes, field widths, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int MAX_SCAN   = 4096;
    localparam int POS_W      = $clog2(MAX_SCAN);
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int RAW_W      = 39;
    localparam int PROD_W     = 36;
    localparam int PLO_W      = 35;
    localparam int PHI_W      = 37;
    localparam int SUM_W      = 56;
    localparam int SPLIT      = 19;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEERING_GAIN = 3'd5;

    typedef struct packed {
        logic        [12:0] scan_length;
        logic        [10:0] crop_count;
        logic        [15:0] collision_threshold;
        logic        [23:0] angle_step;
        logic signed [14:0] angle_offset;
        logic        [15:0] steering_gain;
    } cfg_t;

    typedef enum logic [5:0] {
        ST_RUN  = 6'b000001,
        ST_MUL1 = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_MUL2 = 6'b001000,
        ST_SUM  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    typedef struct packed {
        logic take;
        logic mul1;
        logic add;
        logic mul2;
        logic sum;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_valid;
    } sts_t;

endpackage

// ===== hdl/lgs_cfg.sv =====
// ----------------------------------------------------------------------------
// lgs_cfg: configuration register file
// Holds the six scan and steering registers, written through the
// configuration channel; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module lgs_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data,
    output lgs_pkg::cfg_t                  cfg
);
    import lgs_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_length         <= 13'd1080;
            cfg_reg.crop_count          <= 11'd216;
            cfg_reg.collision_threshold <= 16'd192;
            cfg_reg.angle_step          <= 24'd130342;
            cfg_reg.angle_offset        <= -15'sd10294;
            cfg_reg.steering_gain       <= 16'd4096;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SCAN_LENGTH:   cfg_reg.scan_length         <= cfg_data[12:0];
                CFG_CROP_COUNT:    cfg_reg.crop_count          <= cfg_data[10:0];
                CFG_THRESHOLD:     cfg_reg.collision_threshold <= cfg_data[15:0];
                CFG_ANGLE_STEP:    cfg_reg.angle_step          <= cfg_data[23:0];
                CFG_ANGLE_OFFSET:  cfg_reg.angle_offset        <= $signed(cfg_data[14:0]);
                CFG_STEERING_GAIN: cfg_reg.steering_gain       <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/lgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lgs_ctrl: sequencing controller
// Accepts samples while running; after the last sample of a scan steps the
// datapath through multiply, add, multiply, sum and output load.
// ----------------------------------------------------------------------------
module lgs_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          m_tready,
    input  lgs_pkg::sts_t sts,
    output lgs_pkg::cmd_t cmd,
    output lgs_pkg::state_t state
);
    import lgs_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign state    = state_reg;
    assign s_tready = (state_reg == ST_RUN);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_RUN: begin
                cmd.take = s_tvalid;
                if (s_tvalid && sts.last) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!sts.out_valid || m_tready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/lgs_dp.sv =====
// ----------------------------------------------------------------------------
// lgs_dp: scan tracking and steering arithmetic
// Counts sample positions, tracks first farthest and nearest kept ranges,
// and forms the rounded, saturated steering angle in the output register.
// ----------------------------------------------------------------------------
module lgs_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lgs_pkg::cfg_t                   cfg,
    input  lgs_pkg::cmd_t                   cmd,
    output lgs_pkg::sts_t                   sts,
    input  logic [15:0]                     s_tdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [lgs_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser
);
    import lgs_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SCAN);

    logic [POS_W-1:0]        pos_reg;
    logic [15:0]             far_val_reg, near_val_reg;
    logic [POS_W-1:0]        far_pos_reg, near_pos_reg;
    logic [15:0]             far_val_next, near_val_next;
    logic [POS_W-1:0]        far_pos_next, near_pos_next;
    logic [POS_W-1:0]        gap_idx_reg, near_idx_reg;
    logic                    coll_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic signed [RAW_W-1:0] raw_reg, raw_next, off_term, prod_term;
    logic [PLO_W-1:0]        plo_reg;
    logic signed [PHI_W-1:0] phi_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [31:0]      quot;
    logic signed [15:0]      sat;
    logic [LEN_W-1:0]        len, pos_ext, crop_ext;
    logic                    kept;
    logic [POS_W-1:0]        kidx, idx;
    logic signed [15:0]      angle_reg;
    logic                    out_coll_reg, out_valid_reg;
    logic [POS_W-1:0]        out_gap_reg, out_near_reg;

    always_comb begin
        if (cfg.scan_length == '0) begin
            len = LEN_W'(1);
        end else if (cfg.scan_length > MAX_LEN) begin
            len = MAX_LEN;
        end else begin
            len = cfg.scan_length;
        end
    end

    assign pos_ext  = LEN_W'(pos_reg);
    assign crop_ext = LEN_W'(cfg.crop_count);
    assign kept     = (pos_ext >= crop_ext) && ((pos_ext + crop_ext) < len);
    assign kidx     = pos_reg - POS_W'(cfg.crop_count);
    assign sts.last = (pos_ext + LEN_W'(1)) >= len;
    assign sts.out_valid = out_valid_reg;

    always_comb begin
        far_val_next  = far_val_reg;
        far_pos_next  = far_pos_reg;
        near_val_next = near_val_reg;
        near_pos_next = near_pos_reg;
        if (kept && (s_tdata > far_val_reg)) begin
            far_val_next = s_tdata;
            far_pos_next = kidx;
        end
        if (kept && (s_tdata < near_val_reg)) begin
            near_val_next = s_tdata;
            near_pos_next = kidx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            far_val_reg  <= '0;
            far_pos_reg  <= '0;
            near_val_reg <= '1;
            near_pos_reg <= '0;
        end else if (cmd.take) begin
            if (sts.last) begin
                pos_reg      <= '0;
                far_val_reg  <= '0;
                far_pos_reg  <= '0;
                near_val_reg <= '1;
                near_pos_reg <= '0;
            end else begin
                pos_reg      <= pos_reg + POS_W'(1);
                far_val_reg  <= far_val_next;
                far_pos_reg  <= far_pos_next;
                near_val_reg <= near_val_next;
                near_pos_reg <= near_pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && sts.last) begin
            gap_idx_reg  <= far_pos_next;
            near_idx_reg <= near_pos_next;
            coll_reg     <= near_val_next < cfg.collision_threshold;
        end
    end

    assign idx       = coll_reg ? near_idx_reg : gap_idx_reg;
    assign off_term  = {{12{cfg.angle_offset[14]}}, cfg.angle_offset, 12'b0};
    assign prod_term = $signed({3'b0, prod_reg});
    assign raw_next  = coll_reg ? (-off_term - prod_term) : (off_term + prod_term);

    always_comb begin
        if (coll_reg) begin
            sum_next = {phi_reg, {SPLIT{1'b0}}} + $signed({21'b0, plo_reg})
                     + $signed(SUM_W'(1) << 23);
        end else begin
            sum_next = {{5{raw_reg[RAW_W-1]}}, raw_reg, 12'b0}
                     + $signed(SUM_W'(1) << 23);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            prod_reg <= PROD_W'(cfg.angle_step * idx);
        end
        if (cmd.add) begin
            raw_reg <= raw_next;
        end
        if (cmd.mul2) begin
            plo_reg <= PLO_W'(cfg.steering_gain * raw_reg[SPLIT-1:0]);
            phi_reg <= PHI_W'($signed({1'b0, cfg.steering_gain})
                              * $signed(raw_reg[RAW_W-1:SPLIT]));
        end
        if (cmd.sum) begin
            sum_reg <= sum_next;
        end
    end

    assign quot = sum_reg[SUM_W-1:24];

    always_comb begin
        if (quot > 32'sd32767) begin
            sat = 16'sh7fff;
        end else if (quot < -32'sd32768) begin
            sat = -16'sh8000;
        end else begin
            sat = quot[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            angle_reg    <= sat;
            out_coll_reg <= coll_reg;
            out_gap_reg  <= gap_idx_reg;
            out_near_reg <= near_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_near_reg, out_gap_reg, angle_reg};
    assign m_tuser  = out_coll_reg;

endmodule

// ===== hdl/lidar_gap_steering.sv =====
// ----------------------------------------------------------------------------
// lidar_gap_steering: follow-the-gap steering from a lidar range stream
// One range per item; at the end of each scan one steering result.
//
//   channel  | dir | tdata fields (low bit up)                  | tuser
//   s_       | in  | range_sample[15:0]                         | -
//   m_       | out | steer_cmd, gap_index, nearest_index        | collision
//   cfg_     | in  | index 0..5, data per register              | -
//
// One sample per cycle while running; the last sample of a scan stalls the
// input for the angle arithmetic (multiply, add, multiply, sum, load).
// The output register holds a result until taken; a pending result stalls
// the load of the following scan's result, and the input with it.
// Reset is synchronous, active low; the scan position and trackers clear.
// ----------------------------------------------------------------------------
module lidar_gap_steering (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // range_sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // steer_cmd[15:0], gap_index[27:16], nearest_index[39:28]
    output logic [lgs_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser,   // collision
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lgs_pkg::*;

    cfg_t   cfg;
    cmd_t   cmd;
    sts_t   sts;
    state_t state;

    lgs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    lgs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef ASSERT_OFF
    a_last_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && sts.last) |=> !s_tready)
        else $error("input accepted during end-of-scan arithmetic");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.load))
        else $error("result shown without a load");

    a_load_in_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (state == ST_OUT) && !s_tready)
        else $error("result load outside the output step");
`endif

endmodule
